### rtl/pbsr_pkg.sv
// Shared types and constants for the packed bitmap store.
`default_nettype none
package pbsr_pkg;

  localparam int unsigned MAX_SIDE        = 256;
  localparam int unsigned STORE_WORDS_DEF = 2048;
  localparam int unsigned WORD_BITS       = 32;

  typedef enum logic [2:0] {
    ACT_RD_PIX  = 3'd0,
    ACT_WR_PIX  = 3'd1,
    ACT_RESIZE  = 3'd2,
    ACT_LD_WORD = 3'd3,
    ACT_RD_WORD = 3'd4
  } action_e;

  typedef struct packed {
    logic capture;
    logic calc;
    logic respond;
    logic clr_step;
    logic cpy_step;
    logic flush;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       rs_ok;
    logic       clr_none;
    logic       clr_last;
    logic       cpy_none;
    logic       cpy_last;
  } st_t;

endpackage
`default_nettype wire

### rtl/packed_bitmap_store_with_resize_core.sv
// Top level of the packed one-bit-per-pixel mask store with resize.
//
// channel   signals                               transfer
// command   start, busy, action_i .. word_in_i    start high while busy low
// result    done_o, pixel_out_o .. error_o        done_o high, one cycle
//
// Pixel and word items pass through the EXEC and RESP states; done_o is registered after RESP.
// Resize runs a clear pass and a copy pass: W words cleared in the new layout,
// M pixels of the shared region copied, one per cycle through one bank port.
// Busy stays high until the result is out; no clearing pass after reset.
// Results cannot be stalled; done_o marks each for a single cycle.
`default_nettype none
module packed_bitmap_store_with_resize_core import pbsr_pkg::*; #(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action_i,
  input  wire logic [7:0]  pos_x_i,
  input  wire logic [7:0]  pos_y_i,
  input  wire logic        pixel_in_i,
  input  wire logic [8:0]  new_width_i,
  input  wire logic [8:0]  new_height_i,
  input  wire logic [10:0] word_index_i,
  input  wire logic [31:0] word_in_i,
  output logic             done_o,
  output logic             pixel_out_o,
  output logic      [31:0] word_out_o,
  output logic      [8:0]  cur_width_o,
  output logic      [8:0]  cur_height_o,
  output logic             error_o
);

  cmd_t cmd;
  st_t  st;

  pbsr_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .st_i(st), .cmd_o(cmd)
  );

  pbsr_dp #(.STORE_WORDS(STORE_WORDS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .st_o(st),
    .action_i, .pos_x_i, .pos_y_i, .pixel_in_i, .new_width_i, .new_height_i,
    .word_index_i, .word_in_i,
    .done_o, .pixel_out_o, .word_out_o, .cur_width_o, .cur_height_o, .error_o
  );

endmodule
`default_nettype wire

### rtl/pbsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pbsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/pbsr_ctrl.sv
// Sequencer for item execution and the resize clear/copy walk.
`default_nettype none
module pbsr_ctrl import pbsr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire st_t  st_i,
  output cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RESP, S_CHK, S_CLR, S_CPY, S_DRAIN, S_FLUSH, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.calc = 1'b1;
        state_d = (st_i.act == ACT_RESIZE) ? S_CHK : S_RESP;
      end
      S_RESP: begin
        cmd_o.respond = 1'b1;
        state_d = S_IDLE;
      end
      S_CHK: begin
        if (!st_i.rs_ok) begin
          cmd_o.respond = 1'b1;
          state_d = S_IDLE;
        end else if (!st_i.clr_none) begin
          state_d = S_CLR;
        end else begin
          state_d = st_i.cpy_none ? S_FLUSH : S_CPY;
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) begin
          state_d = st_i.cpy_none ? S_FLUSH : S_CPY;
        end
      end
      S_CPY: begin
        cmd_o.cpy_step = 1'b1;
        if (st_i.cpy_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_FLUSH;
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.commit  = 1'b1;
        cmd_o.respond = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

### rtl/pbsr_dp.sv
// Datapath: item registers, size state, two banks and the resize copy pipe.
`default_nettype none
module pbsr_dp import pbsr_pkg::*; #(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output st_t              st_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [7:0]  pos_x_i,
  input  wire logic [7:0]  pos_y_i,
  input  wire logic        pixel_in_i,
  input  wire logic [8:0]  new_width_i,
  input  wire logic [8:0]  new_height_i,
  input  wire logic [10:0] word_index_i,
  input  wire logic [31:0] word_in_i,
  output logic             done_o,
  output logic             pixel_out_o,
  output logic      [31:0] word_out_o,
  output logic      [8:0]  cur_width_o,
  output logic      [8:0]  cur_height_o,
  output logic             error_o
);

  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned UW = $clog2(STORE_WORDS + 1);

  logic [2:0]  act_q;
  logic [7:0]  x_q, y_q;
  logic        pix_q;
  logic [8:0]  nw_q, nh_q;
  logic [10:0] widx_q;
  logic [31:0] win_q;
  logic [8:0]  w_q, h_q;
  logic [UW-1:0] used_q;
  logic        active_q;
  logic [17:0] prod_q;
  logic [AW-1:0] clr_q;
  logic [8:0]  i_q, j_q;
  logic [16:0] so_q, dn_q, so_row_q, dn_row_q;
  logic        v1_q;
  logic [4:0]  sb1_q, db1_q;
  logic [16:0] dw1_q;
  logic [31:0] acc_q;
  logic [16:0] acc_idx_q;
  logic        acc_v_q;
  logic        done_q, pix_out_q, err_q;
  logic [31:0] wout_q;

  logic [16:0] pix_n;
  logic        pix_err, word_err, rs_ok, src_bit, acc_new;
  logic [8:0]  mw, mh;
  logic [13:0] words_new;
  logic [31:0] rd_data, rd0, rd1, pmask, dmask, wd;
  logic [AW-1:0] wa, ra;
  logic        we, to_dst, wsel;

  assign pix_n     = (17'(y_q) * 17'(w_q)) + 17'(x_q);
  assign pix_err   = ({1'b0, x_q} >= w_q) || ({1'b0, y_q} >= h_q);
  assign word_err  = 32'(widx_q) >= 32'(used_q);
  assign mw        = (w_q < nw_q) ? w_q : nw_q;
  assign mh        = (h_q < nh_q) ? h_q : nh_q;
  assign words_new = 14'((19'(prod_q) + 19'd31) >> 5);
  assign rs_ok     = (32'(nw_q) <= MAX_SIDE) && (32'(nh_q) <= MAX_SIDE) &&
                     (32'(words_new) <= STORE_WORDS);
  assign rd_data   = active_q ? rd1 : rd0;
  assign pmask     = 32'd1 << (~pix_n[4:0]);
  assign dmask     = 32'd1 << (~db1_q);
  assign src_bit   = rd_data[~sb1_q];
  assign acc_new   = !acc_v_q || (dw1_q != acc_idx_q);

  assign st_o.act      = act_q;
  assign st_o.rs_ok    = rs_ok;
  assign st_o.clr_none = (words_new == 14'd0);
  assign st_o.clr_last = (32'(clr_q) + 32'd1) == 32'(words_new);
  assign st_o.cpy_none = (mw == 9'd0) || (mh == 9'd0);
  assign st_o.cpy_last = (i_q == mw - 9'd1) && (j_q == mh - 9'd1);

  always_comb begin
    if (cmd_i.cpy_step) begin
      ra = AW'(so_q >> 5);
    end else if (act_q == ACT_LD_WORD || act_q == ACT_RD_WORD) begin
      ra = AW'(widx_q);
    end else begin
      ra = AW'(pix_n >> 5);
    end
  end

  always_comb begin
    we     = 1'b0;
    to_dst = 1'b0;
    wa     = '0;
    wd     = '0;
    if (cmd_i.calc && act_q == ACT_LD_WORD && !word_err) begin
      we = 1'b1;
      wa = AW'(widx_q);
      wd = win_q;
    end
    if (cmd_i.respond && act_q == ACT_WR_PIX && !pix_err) begin
      we = 1'b1;
      wa = AW'(pix_n >> 5);
      wd = pix_q ? (rd_data | pmask) : (rd_data & ~pmask);
    end
    if (cmd_i.clr_step) begin
      we     = 1'b1;
      to_dst = 1'b1;
      wa     = clr_q;
    end
    if ((v1_q && acc_v_q && dw1_q != acc_idx_q) || (cmd_i.flush && acc_v_q)) begin
      we     = 1'b1;
      to_dst = 1'b1;
      wa     = AW'(acc_idx_q);
      wd     = acc_q;
    end
  end

  assign wsel = to_dst ? ~active_q : active_q;

  pbsr_ram #(.WIDTH(WORD_BITS), .DEPTH(STORE_WORDS)) u_bank0 (
    .clk_i, .we_i(we && !wsel), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd0)
  );

  pbsr_ram #(.WIDTH(WORD_BITS), .DEPTH(STORE_WORDS)) u_bank1 (
    .clk_i, .we_i(we && wsel), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd1)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      pix_q  <= pixel_in_i;
      nw_q   <= new_width_i;
      nh_q   <= new_height_i;
      widx_q <= word_index_i;
      win_q  <= word_in_i;
    end
    if (cmd_i.calc) begin
      prod_q <= 18'(nw_q) * 18'(nh_q);
    end
    if (cmd_i.capture) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
    if (cmd_i.capture) begin
      i_q      <= '0;
      j_q      <= '0;
      so_q     <= '0;
      dn_q     <= '0;
      so_row_q <= '0;
      dn_row_q <= '0;
    end else if (cmd_i.cpy_step) begin
      if (i_q == mw - 9'd1) begin
        i_q      <= '0;
        j_q      <= j_q + 9'd1;
        so_row_q <= so_row_q + 17'(w_q);
        dn_row_q <= dn_row_q + 17'(nw_q);
        so_q     <= so_row_q + 17'(w_q);
        dn_q     <= dn_row_q + 17'(nw_q);
      end else begin
        i_q  <= i_q + 9'd1;
        so_q <= so_q + 17'd1;
        dn_q <= dn_q + 17'd1;
      end
    end
    sb1_q <= so_q[4:0];
    db1_q <= dn_q[4:0];
    dw1_q <= dn_q >> 5;
    if (v1_q) begin
      acc_idx_q <= dw1_q;
      acc_q     <= (acc_new ? 32'd0 : acc_q) | (src_bit ? dmask : 32'd0);
    end
    if (cmd_i.respond) begin
      pix_out_q <= 1'b0;
      wout_q    <= '0;
      case (act_q)
        ACT_RD_PIX, ACT_WR_PIX: begin
          err_q <= pix_err;
          if (act_q == ACT_RD_PIX && !pix_err) begin
            pix_out_q <= (rd_data & pmask) != 32'd0;
          end
        end
        ACT_LD_WORD, ACT_RD_WORD: begin
          err_q <= word_err;
          if (act_q == ACT_RD_WORD && !word_err) begin
            wout_q <= rd_data;
          end
        end
        ACT_RESIZE: err_q <= !rs_ok;
        default:    err_q <= 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      w_q      <= '0;
      h_q      <= '0;
      used_q   <= '0;
      v1_q     <= 1'b0;
      acc_v_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      v1_q   <= cmd_i.cpy_step;
      done_q <= cmd_i.respond;
      if (cmd_i.capture) begin
        acc_v_q <= 1'b0;
      end else if (v1_q) begin
        acc_v_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        active_q <= ~active_q;
        w_q      <= nw_q;
        h_q      <= nh_q;
        used_q   <= UW'(words_new);
      end
    end
  end

  assign done_o       = done_q;
  assign pixel_out_o  = pix_out_q;
  assign word_out_o   = wout_q;
  assign error_o      = err_q;
  assign cur_width_o  = w_q;
  assign cur_height_o = h_q;

endmodule
`default_nettype wire

### rtl/pbsr_checker.sv
// Port-level checks for the bitmap store, bound to the top level.
`default_nettype none
module pbsr_checker import pbsr_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  action_i,
  input wire logic        done_o,
  input wire logic        pixel_out_o,
  input wire logic [31:0] word_out_o,
  input wire logic        error_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after transfer");

  a_bad_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i > ACT_RD_WORD) |-> ##3 (done_o && error_o))
    else $error("unknown action not refused");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o) |-> (!pixel_out_o && word_out_o == 32'd0))
    else $error("refused item returned data");

endmodule

bind packed_bitmap_store_with_resize_core pbsr_checker u_pbsr_checker (
  .clk_i, .rst_ni, .start, .busy, .action_i, .done_o, .pixel_out_o, .word_out_o, .error_o
);
`default_nettype wire
